FILE: hw/rtl/lac_pkg.sv
// lac_pkg: shared types and constants for the longitudinal acceleration selector
// used by lac_alu, lac_div and longitudinal_accel_selector
`timescale 1ns / 1ps
`default_nettype none
package lac_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned ModeW = 3;
  localparam int unsigned InDataW = 208;
  localparam int unsigned InUserW = 3;
  localparam int unsigned OutDataW = 64;

  localparam logic signed [WordW-1:0] WordMax = 32'sh7FFF_FFFF;
  localparam logic signed [WordW-1:0] WordMin = 32'sh8000_0000;
  localparam logic signed [WordW-1:0] TooCloseLimit = -32'sd6554;

  localparam logic [CfgAddrW-1:0] RegTimeHeadway = 4'd0;
  localparam logic [CfgAddrW-1:0] RegStandstill = 4'd1;
  localparam logic [CfgAddrW-1:0] RegComfBrake = 4'd2;
  localparam logic [CfgAddrW-1:0] RegFollowGain = 4'd3;
  localparam logic [CfgAddrW-1:0] RegSpeedGain = 4'd4;
  localparam logic [CfgAddrW-1:0] RegLightHeadway = 4'd5;
  localparam logic [CfgAddrW-1:0] RegComfAccel = 4'd6;
  localparam logic [CfgAddrW-1:0] RegMaxBrake = 4'd7;

  localparam logic [ModeW-1:0] ModeComfort = 3'd0;
  localparam logic [ModeW-1:0] ModeSpeed = 3'd1;
  localparam logic [ModeW-1:0] ModeFollow = 3'd2;
  localparam logic [ModeW-1:0] ModeLight = 3'd3;
  localparam logic [ModeW-1:0] ModeTooClose = 3'd4;

  typedef enum logic [1:0] {
    AluAdd,
    AluSub,
    AluMul
  } alu_op_t;

  typedef struct packed {
    alu_op_t                 op;
    logic signed [WordW-1:0] a;
    logic signed [WordW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                    start;
    logic signed [WordW-1:0] a;
    logic signed [WordW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [WordW-1:0] q;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lac_alu.sv
// lac_alu: saturating add, subtract and q16.16 multiply, result registered
// depends on lac_pkg
`timescale 1ns / 1ps
`default_nettype none
module lac_alu (
  input  wire logic                             clk,
  input  wire lac_pkg::alu_req_t                req,
  output logic signed [lac_pkg::WordW-1:0]      res
);
  import lac_pkg::*;

  logic signed [2*WordW-1:0] prod;
  logic signed [2*WordW-17:0] prod_sh;
  logic signed [WordW:0] sum;
  logic signed [WordW-1:0] res_next;

  always_comb begin
    prod = (2*WordW)'(req.a) * (2*WordW)'(req.b);
    // arithmetic shift rounds toward minus infinity
    prod_sh = prod[2*WordW-1:16];
    sum = '0;
    res_next = '0;
    unique case (req.op)
      AluAdd: begin
        sum = {req.a[WordW-1], req.a} + {req.b[WordW-1], req.b};
      end
      AluSub: begin
        sum = {req.a[WordW-1], req.a} - {req.b[WordW-1], req.b};
      end
      default: begin
        sum = '0;
      end
    endcase
    if (req.op == AluMul) begin
      if (prod_sh > 48'sh0000_7FFF_FFFF) begin
        res_next = WordMax;
      end else if (prod_sh < -48'sh0000_8000_0000) begin
        res_next = WordMin;
      end else begin
        res_next = prod_sh[WordW-1:0];
      end
    end else begin
      if (sum[WordW] != sum[WordW-1]) begin
        res_next = sum[WordW] ? WordMin : WordMax;
      end else begin
        res_next = sum[WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lac_div.sv
// lac_div: radix-2 restoring divider for q16.16, (a*65536)/b toward zero, saturated
// depends on lac_pkg
`timescale 1ns / 1ps
`default_nettype none
module lac_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lac_pkg::div_req_t req,
  output lac_pkg::div_rsp_t      rsp
);
  import lac_pkg::*;

  localparam int unsigned NumW = WordW + 16;

  logic busy;
  logic fin;
  logic [5:0] cnt;
  logic [NumW-1:0] num;
  logic [NumW-1:0] quo;
  logic [WordW-1:0] den;
  logic [WordW-1:0] rem;
  logic neg;
  logic [WordW:0] rem_sh;
  logic [WordW-1:0] a_mag;
  logic [WordW-1:0] b_mag;

  always_comb begin
    rem_sh = {rem, num[NumW-1]};
    a_mag = req.a[WordW-1] ? (~req.a + 32'd1) : req.a;
    b_mag = req.b[WordW-1] ? (~req.b + 32'd1) : req.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      fin <= 1'b0;
      if (req.start) begin
        if (req.b == '0) begin
          rsp.q <= req.a[WordW-1] ? WordMin : WordMax;
          rsp.done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt <= '0;
          num <= {a_mag, 16'd0};
          den <= b_mag;
          rem <= '0;
          quo <= '0;
          neg <= req.a[WordW-1] ^ req.b[WordW-1];
        end
      end else if (busy) begin
        num <= {num[NumW-2:0], 1'b0};
        if (rem_sh >= {1'b0, den}) begin
          rem <= WordW'(rem_sh - {1'b0, den});
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WordW-1:0];
          quo <= {quo[NumW-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(NumW - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        rsp.done <= 1'b1;
        if (neg) begin
          rsp.q <= (quo > 48'h0000_8000_0000) ? WordMin : (~quo[WordW-1:0] + 32'd1);
        end else begin
          rsp.q <= (quo > 48'h0000_7FFF_FFFF) ? WordMax : quo[WordW-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/longitudinal_accel_selector.sv
// longitudinal_accel_selector: top level with the step sequencer and i/o registers
// depends on lac_pkg, lac_alu, lac_div
//
// One word in gives one word out. The sequencer runs every operation of the
// control law through one saturating add/multiply unit (one operation per
// cycle) and one radix-2 divider, which skips its bit loop when the divisor
// is zero. The divisions set the pace. A word with no leader and no light
// runs only the speed steps; a leader adds the following-gap steps, the
// connected or the unconnected law and the too-close check, and a light
// adds the light steps. s_tready is high only while the block is idle; a
// finished word waits in the output register while the next one is taken
// in and worked on, and that next result is held back until the register
// is free.
`timescale 1ns / 1ps
`default_nettype none
module longitudinal_accel_selector (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [lac_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [lac_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // ego_speed, gap, relative_speed, leader_speed, lead_acc,
  // speed_reference, light_offset, light_rate, zero pad
  input  wire logic [lac_pkg::InDataW-1:0]   s_tdata,
  // leader_present, both_connected, light_present
  input  wire logic [lac_pkg::InUserW-1:0]   s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // acceleration, following_gap_error
  output logic [lac_pkg::OutDataW-1:0]       m_tdata,
  // active_mode
  output logic [lac_pkg::ModeW-1:0]          m_tuser
);
  import lac_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_SPD0, S_SPD1, S_SPD2,
    S_L0, S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_L8, S_L9, S_L10, S_L11,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_C5,
    S_U0, S_U1, S_U2,
    S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6,
    S_T0, S_T1, S_T2, S_T3,
    S_OUT
  } state_t;

  state_t state;
  logic div_run;
  logic out_load;

  logic [18:0] th;
  logic [20:0] sd;
  logic [19:0] cb;
  logic [18:0] fg;
  logic [18:0] sg;
  logic [18:0] beta;
  logic [19:0] ca;
  logic [19:0] mb;

  logic signed [WordW-1:0] ego, gap, rel, lv, la, vref, h3, dht;
  logic leader, conn, light;
  logic signed [WordW-1:0] t0, t1, best, held;
  logic [ModeW-1:0] mode;

  logic signed [WordW-1:0] th_w, sd_w, cb_w, fg_w, sg_w, beta_w, mb_w, mb_neg;
  alu_req_t alu_req;
  logic signed [WordW-1:0] alu_res;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic is_div;

  assign th_w = {13'd0, th};
  assign sd_w = {11'd0, sd};
  assign cb_w = {12'd0, cb};
  assign fg_w = {13'd0, fg};
  assign sg_w = {13'd0, sg};
  assign beta_w = {13'd0, beta};
  assign mb_w = {12'd0, mb};
  assign mb_neg = -mb_w;

  lac_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  lac_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // operand selection; alu_res holds the result of the previous state's operation
  always_comb begin
    alu_req = '{op: AluAdd, a: '0, b: '0};
    div_req = '{start: 1'b0, a: '0, b: '0};
    is_div = 1'b0;
    unique case (state)
      S_SPD0: alu_req = '{op: AluSub, a: vref, b: ego};
      S_SPD1: alu_req = '{op: AluMul, a: sg_w, b: alu_res};
      S_L0:   alu_req = '{op: AluMul, a: ego, b: ego};
      S_L1:   alu_req = '{op: AluMul, a: lv, b: lv};
      S_L2:   alu_req = '{op: AluSub, a: t0, b: alu_res};
      S_L3:   alu_req = '{op: AluAdd, a: cb_w, b: cb_w};
      S_L4: begin
        is_div = 1'b1;
        div_req = '{start: 1'b0, a: t0, b: alu_res};
      end
      S_L5:   alu_req = '{op: AluMul, a: th_w, b: ego};
      S_L6:   alu_req = '{op: AluAdd, a: alu_res, b: sd_w};
      S_L7:   alu_req = '{op: AluAdd, a: alu_res, b: t0};
      S_L8:   alu_req = '{op: AluSub, a: gap, b: alu_res};
      S_L9:   alu_req = '{op: AluMul, a: fg_w, b: alu_res};
      S_L10:  alu_req = '{op: AluSub, a: alu_res, b: rel};
      S_C0: begin
        is_div = 1'b1;
        div_req = '{start: 1'b0, a: la, b: cb_w};
      end
      S_C1:   alu_req = '{op: AluMul, a: t1, b: lv};
      S_C2:   alu_req = '{op: AluAdd, a: t0, b: alu_res};
      S_C3:   alu_req = '{op: AluMul, a: alu_res, b: cb_w};
      S_C4:   alu_req = '{op: AluAdd, a: cb_w, b: ego};
      S_C5: begin
        is_div = 1'b1;
        div_req = '{start: 1'b0, a: t0, b: alu_res};
      end
      S_U0: begin
        is_div = 1'b1;
        div_req = '{start: 1'b0, a: ego, b: cb_w};
      end
      S_U1:   alu_req = '{op: AluAdd, a: th_w, b: t1};
      S_U2: begin
        is_div = 1'b1;
        div_req = '{start: 1'b0, a: t0, b: alu_res};
      end
      S_G0:   alu_req = '{op: AluMul, a: beta_w, b: cb_w};
      S_G1:   alu_req = '{op: AluAdd, a: alu_res, b: ego};
      S_G2: begin
        is_div = 1'b1;
        div_req = '{start: 1'b0, a: cb_w, b: alu_res};
      end
      S_G3:   alu_req = '{op: AluSub, a: dht, b: ego};
      S_G4:   alu_req = '{op: AluAdd, a: alu_res, b: h3};
      S_G5:   alu_req = '{op: AluMul, a: t0, b: alu_res};
      S_T0:   alu_req = '{op: AluMul, a: th_w, b: ego};
      S_T1:   alu_req = '{op: AluSub, a: gap, b: alu_res};
      S_T2:   alu_req = '{op: AluSub, a: alu_res, b: sd_w};
      default: begin
        alu_req = '{op: AluAdd, a: '0, b: '0};
      end
    endcase
    // the divider latches its operands in the first cycle of a divide state
    div_req.start = is_div && !div_run;
  end

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_run <= 1'b0;
      m_tvalid <= 1'b0;
      held <= '0;
      th <= 19'd65536;
      sd <= 21'd196608;
      cb <= 20'd131072;
      fg <= 19'd32768;
      sg <= 19'd32768;
      beta <= 19'd65536;
      ca <= 20'd131072;
      mb <= 20'd393216;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          RegTimeHeadway:  th <= cfg_data[18:0];
          RegStandstill:   sd <= cfg_data[20:0];
          RegComfBrake:    cb <= cfg_data[19:0];
          RegFollowGain:   fg <= cfg_data[18:0];
          RegSpeedGain:    sg <= cfg_data[18:0];
          RegLightHeadway: beta <= cfg_data[18:0];
          RegComfAccel:    ca <= cfg_data[19:0];
          RegMaxBrake:     mb <= cfg_data[19:0];
          default: begin
          end
        endcase
      end

      // hand the finished word to the output register once it is free
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata <= {held, best};
        m_tuser <= mode;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (div_req.start) begin
        div_run <= 1'b1;
      end else if (div_run && div_rsp.done) begin
        div_run <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ego <= {9'd0, s_tdata[22:0]};
            gap <= s_tdata[54:23];
            rel <= {{8{s_tdata[78]}}, s_tdata[78:55]};
            lv <= {9'd0, s_tdata[101:79]};
            la <= {{10{s_tdata[123]}}, s_tdata[123:102]};
            vref <= {9'd0, s_tdata[146:124]};
            h3 <= s_tdata[178:147];
            dht <= {{9{s_tdata[201]}}, s_tdata[201:179]};
            leader <= s_tuser[0];
            conn <= s_tuser[1];
            light <= s_tuser[2];
            best <= {12'd0, ca};
            mode <= ModeComfort;
            state <= S_SPD0;
          end
        end
        S_SPD0: state <= S_SPD1;
        S_SPD1: state <= S_SPD2;
        S_SPD2: begin
          if (alu_res < best) begin
            best <= alu_res;
            mode <= ModeSpeed;
          end
          state <= leader ? S_L0 : (light ? S_G0 : S_OUT);
        end
        S_L0: state <= S_L1;
        S_L1: begin
          t0 <= alu_res;
          state <= S_L2;
        end
        S_L2: state <= S_L3;
        S_L3: begin
          t0 <= alu_res;
          state <= S_L4;
        end
        S_L4: begin
          if (div_run && div_rsp.done) begin
            t0 <= div_rsp.q;
            state <= S_L5;
          end
        end
        S_L5: state <= S_L6;
        S_L6: state <= S_L7;
        S_L7: state <= S_L8;
        S_L8: state <= S_L9;
        S_L9: begin
          held <= alu_res;
          state <= S_L10;
        end
        S_L10: state <= S_L11;
        S_L11: begin
          t0 <= alu_res;
          state <= conn ? S_C0 : S_U0;
        end
        S_C0: begin
          if (div_run && div_rsp.done) begin
            t1 <= div_rsp.q;
            state <= S_C1;
          end
        end
        S_C1: state <= S_C2;
        S_C2: state <= S_C3;
        S_C3: state <= S_C4;
        S_C4: begin
          t0 <= alu_res;
          state <= S_C5;
        end
        S_C5, S_U2: begin
          if (div_run && div_rsp.done) begin
            if (div_rsp.q < best) begin
              best <= div_rsp.q;
              mode <= ModeFollow;
            end
            state <= light ? S_G0 : S_T0;
          end
        end
        S_U0: begin
          if (div_run && div_rsp.done) begin
            t1 <= div_rsp.q;
            state <= S_U1;
          end
        end
        S_U1: state <= S_U2;
        S_G0: state <= S_G1;
        S_G1: state <= S_G2;
        S_G2: begin
          if (div_run && div_rsp.done) begin
            t0 <= div_rsp.q;
            state <= S_G3;
          end
        end
        S_G3: state <= S_G4;
        S_G4: state <= S_G5;
        S_G5: state <= S_G6;
        S_G6: begin
          if (alu_res < best) begin
            best <= alu_res;
            mode <= ModeLight;
          end
          state <= leader ? S_T0 : S_OUT;
        end
        S_T0: state <= S_T1;
        S_T1: state <= S_T2;
        S_T2: state <= S_T3;
        S_T3: begin
          // plain gap error below the limit: floor at max braking
          if (alu_res < TooCloseLimit) begin
            mode <= ModeTooClose;
            if (best < mb_neg) begin
              best <= mb_neg;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
